// File: hdl/timer_slot_pool_core_defines.svh
// Assertion macros used by the timer slot pool core.
`ifndef TIMER_SLOT_POOL_CORE_DEFINES_SVH
`define TIMER_SLOT_POOL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tsp_pkg.sv
// Shared constants and types of the timer slot pool.
`default_nettype none

package tsp_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;

  localparam int OP_W    = 2;
  localparam int TIME_W  = 48;
  localparam int DELAY_W = 32;
  localparam int TAG_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 2;

  // Operation codes of an input beat
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

  // Status codes of a result beat
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;

  // One slot entry as stored in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0]  ring;
    logic [DELAY_W-1:0] period;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // One result beat without its last flag
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              fired;
    logic [TAG_W-1:0]  fired_tag;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/tsp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read one word; hold the last word while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/timer_slot_pool_core.sv
// Timer slot pool top level: busy flags, free-slot search, expiry scan over the slot memory.
// Cancel: result staged on accept, sent from the flush state once the output is free.
// Schedule: one busy flag examined per cycle in the free-slot search. Check: the scan reads
// one entry per cycle through the single read port of the slot memory while no output stall holds it.
// One item in flight: in_ready returns with the final result beat, so items follow that pace.
// Reset clears the busy flags and control state at once; no clearing pass, memory undefined.
`default_nettype none
`include "timer_slot_pool_core_defines.svh"

module timer_slot_pool_core #(
  parameter int SLOTS = tsp_pkg::SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tsp_pkg::OP_W-1:0]     in_operation,
  input  wire logic [tsp_pkg::TIME_W-1:0]   in_now_ms,
  input  wire logic [tsp_pkg::DELAY_W-1:0]  in_delay_ms,
  input  wire logic                         in_repeating,
  input  wire logic [tsp_pkg::TAG_W-1:0]    in_tag,
  input  wire logic                         in_replace_valid,
  input  wire logic [tsp_pkg::SLOT_W-1:0]   in_slot_index,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [tsp_pkg::STAT_W-1:0]   out_status,
  output logic      [tsp_pkg::SLOT_W-1:0]   out_slot,
  output logic                              out_fired,
  output logic      [tsp_pkg::TAG_W-1:0]    out_fired_tag,
  output logic                              out_last
);

  import tsp_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (SW > SLOT_W) ? SW + 1 : SLOT_W + 1;
  localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [CW-1:0]    SLOT_LIM  = CW'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIND  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic              rd_more_r, rd_more_nxt;
  logic              eval_v_r, eval_v_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload state
  logic [SW-1:0]      eval_idx_r, eval_idx_nxt;
  res_t               pend_r, pend_nxt;
  res_t               out_r, out_nxt;
  logic               out_last_r, out_last_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic               rep_r, rep_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic               repl_r, repl_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;

  // slot memory port
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [SW-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t        rd;

  logic              out_free;
  logic              hit;
  logic              stall;
  logic              done;
  logic [TIME_W-1:0] ring_sum;
  logic [SW-1:0]     idx_sw;
  logic [SW-1:0]     in_idx_sw;
  logic              idx_ok;
  logic              in_idx_ok;

  tsp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign ring_sum  = rd.ring + TIME_W'(rd.period);
  assign idx_sw    = SW'(idx_r);
  assign in_idx_sw = SW'(in_slot_index);
  assign idx_ok    = CW'(idx_r) < SLOT_LIM;
  assign in_idx_ok = CW'(in_slot_index) < SLOT_LIM;
  assign out_free  = !out_valid_r || out_ready;
  assign hit       = eval_v_r && busy_r[eval_idx_r] && (rd.ring <= now_r);
  assign stall     = hit && pend_v_r && !out_free;
  assign in_ready  = (state_r == ST_IDLE);

  // Next-state logic for search, scan and result staging
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    scan_nxt      = scan_r;
    rd_more_nxt   = rd_more_r;
    eval_v_nxt    = eval_v_r;
    eval_idx_nxt  = eval_idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    now_nxt       = now_r;
    delay_nxt     = delay_r;
    rep_nxt       = rep_r;
    tag_nxt       = tag_r;
    repl_nxt      = repl_r;
    idx_nxt       = idx_r;
    ram_we        = 1'b0;
    ram_waddr     = eval_idx_r;
    ram_wdata     = '{ring: ring_sum, period: rd.period, tag: rd.tag};
    ram_re        = 1'b0;
    ram_raddr     = scan_r;
    done          = 1'b0;

    // drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_now_ms;
          delay_nxt = (in_delay_ms == '0) ? DELAY_W'(1) : in_delay_ms;
          rep_nxt   = in_repeating;
          tag_nxt   = in_tag;
          repl_nxt  = in_replace_valid;
          idx_nxt   = in_slot_index;
          case (in_operation)
            OP_SCHEDULE: begin
              scan_nxt  = '0;
              state_nxt = ST_FIND;
            end
            OP_CANCEL: begin
              if (in_idx_ok && busy_r[in_idx_sw]) begin
                busy_nxt[in_idx_sw] = 1'b0;
                pend_nxt = '{status: STAT_OK, slot: in_slot_index, fired: 1'b0,
                             fired_tag: '0};
              end else begin
                pend_nxt = '{status: STAT_INACTIVE, slot: in_slot_index, fired: 1'b0,
                             fired_tag: '0};
              end
              pend_v_nxt = 1'b1;
              state_nxt  = ST_FLUSH;
            end
            OP_CHECK: begin
              scan_nxt    = '0;
              rd_more_nxt = 1'b1;
              eval_v_nxt  = 1'b0;
              cnt_nxt     = '0;
              pend_v_nxt  = 1'b0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_FIND: begin
        if (!busy_r[scan_r]) begin
          // claim the slot, then release the replaced one if it is in range and busy or is the claimed slot
          ram_we    = 1'b1;
          ram_waddr = scan_r;
          ram_wdata = '{ring: now_r + TIME_W'(delay_r),
                        period: rep_r ? delay_r : '0, tag: tag_r};
          busy_nxt[scan_r] = 1'b1;
          if (repl_r && idx_ok && (busy_r[idx_sw] || idx_sw == scan_r)) begin
            busy_nxt[idx_sw] = 1'b0;
          end
          pend_nxt   = '{status: STAT_OK, slot: SLOT_W'(scan_r), fired: 1'b0,
                         fired_tag: '0};
          pend_v_nxt = 1'b1;
          state_nxt  = ST_FLUSH;
        end else if (scan_r == LAST_SLOT) begin
          pend_nxt   = '{status: STAT_FULL, slot: '0, fired: 1'b0, fired_tag: '0};
          pend_v_nxt = 1'b1;
          state_nxt  = ST_FLUSH;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // issue the next read
          if (rd_more_r) begin
            ram_re       = 1'b1;
            eval_v_nxt   = 1'b1;
            eval_idx_nxt = scan_r;
            scan_nxt     = scan_r + SW'(1);
            rd_more_nxt  = (scan_r != LAST_SLOT);
          end else begin
            eval_v_nxt = 1'b0;
          end
          // evaluate the entry from the last issued read
          if (hit) begin
            ram_we = 1'b1;
            if (rd.period == '0) begin
              busy_nxt[eval_idx_r] = 1'b0;
            end
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt   = '{status: STAT_OK, slot: SLOT_W'(eval_idx_r), fired: 1'b1,
                           fired_tag: rd.tag};
            pend_v_nxt = 1'b1;
            cnt_nxt    = cnt_r + CNT_W'(1);
          end
          done = (hit && cnt_r == CNT_CAP) || !rd_more_r;
          if (done) begin
            eval_v_nxt  = 1'b0;
            rd_more_nxt = 1'b0;
            state_nxt   = ST_FLUSH;
            if (!pend_v_nxt) begin
              pend_nxt   = '{status: STAT_OK, slot: '0, fired: 1'b0, fired_tag: '0};
              pend_v_nxt = 1'b1;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      scan_r      <= '0;
      rd_more_r   <= 1'b0;
      eval_v_r    <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      scan_r      <= scan_nxt;
      rd_more_r   <= rd_more_nxt;
      eval_v_r    <= eval_v_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    eval_idx_r <= eval_idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    now_r      <= now_nxt;
    delay_r    <= delay_nxt;
    rep_r      <= rep_nxt;
    tag_r      <= tag_nxt;
    repl_r     <= repl_nxt;
    idx_r      <= idx_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_slot      = out_r.slot;
  assign out_fired     = out_r.fired;
  assign out_fired_tag = out_r.fired_tag;
  assign out_last      = out_last_r;

  // Checks on the scan and staging logic
  `TSP_ASSERT_NOW(a_idle_no_pend, state_r == ST_IDLE, !pend_v_r,
    "staged result left behind in idle")
  `TSP_ASSERT_NOW(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(MAX_RESULTS),
    "check emitted more results than the cap")
  `TSP_ASSERT_NOW(a_eval_in_scan, eval_v_r, state_r == ST_SCAN,
    "memory read data evaluated outside a scan")
  `TSP_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
    "write and read of the same slot entry in one cycle")
  `TSP_ASSERT_NEXT(a_flush_ends, state_r == ST_FLUSH && out_free,
    state_r == ST_IDLE && out_valid_r && out_last_r,
    "final result beat not delivered on flush")

endmodule

`default_nettype wire
